@@ sv/bkt_pkg.sv @@
// ----------------------------------------------------------------------------
// Bearing tracker package
// Step codes, sequence tables, register indexes and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package bkt_pkg;

  // Angle resolution: 1/2^ANGLE_FRAC_BITS degree. The 16-bit angle fields
  // hold the full circle at this resolution or a coarser one.
  localparam int ANGLE_FRAC_BITS = 7;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Steps that start the shared multiply-divide unit.
  localparam step_t ST_NONE     = 5'd0;
  localparam step_t K_MEAS_MOD  = 5'd1;
  localparam step_t K_VEL_T     = 5'd2;
  localparam step_t K_RES_MOD   = 5'd3;
  localparam step_t K_PAV_2T    = 5'd4;
  localparam step_t K_PVV_TT    = 5'd5;
  localparam step_t K_PVV_T     = 5'd6;
  localparam step_t K_G1        = 5'd7;
  localparam step_t K_G2        = 5'd8;
  localparam step_t K_K4        = 5'd9;
  localparam step_t K_K3        = 5'd10;
  localparam step_t K_K2        = 5'd11;
  localparam step_t K_K1        = 5'd12;
  // Steps that write a finished unit result back into the state.
  localparam step_t W_MEAS      = 5'd13;
  localparam step_t W_AZ        = 5'd14;
  localparam step_t W_PAA_ADD   = 5'd15;
  localparam step_t W_PAV_SET   = 5'd16;
  localparam step_t W_VEL       = 5'd17;
  localparam step_t W_PVV_SUB   = 5'd18;
  localparam step_t W_PVA_SUB   = 5'd19;
  localparam step_t W_PAV_SUB   = 5'd20;
  localparam step_t W_PAA_SUB   = 5'd21;
  // Single-cycle actions.
  localparam step_t A_START     = 5'd22;
  localparam step_t A_QNOISE    = 5'd23;
  localparam step_t A_INNOV     = 5'd24;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_MEAS        = 4'd0;
  localparam pc_t PC_PREDICT     = 4'd1;
  localparam pc_t PC_PREDICT_END = 4'd5;
  localparam pc_t PC_UPDATE      = 4'd6;
  localparam pc_t PC_LAST        = 4'd12;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_AZ_NOISE  = 2'd0;
  localparam reg_idx_t REG_VEL_NOISE = 2'd1;
  localparam reg_idx_t REG_INIT_VVAR = 2'd2;

  localparam int DT_MAX      = 1000;
  localparam int MS_PER_S    = 1000;
  localparam int MS2_PER_S2  = 1000000;
  localparam int VAR_MIN     = 256;
  localparam int VEL_STEP    = 1 << 20;
  localparam int VEL_MAX     = 65535;
  localparam int VEL_MIN     = -65536;

  typedef struct packed {
    logic  load;
    logic  emit;
    step_t step;
  } bkt_cmd_t;

  typedef struct packed {
    logic mdu_done;
    logic op;
    logic tracking;
    logic s_pos;
    logic out_free;
  } bkt_sts_t;

  // Unit operation started at each sequence position.
  function automatic step_t kick_of(input pc_t pc);
    step_t k;
    unique case (pc)
      4'd0:    k = K_MEAS_MOD;
      4'd1:    k = K_VEL_T;
      4'd2:    k = K_RES_MOD;
      4'd3:    k = K_PAV_2T;
      4'd4:    k = K_PVV_TT;
      4'd5:    k = K_PVV_T;
      4'd6:    k = K_G1;
      4'd7:    k = K_RES_MOD;
      4'd8:    k = K_G2;
      4'd9:    k = K_K4;
      4'd10:   k = K_K3;
      4'd11:   k = K_K2;
      4'd12:   k = K_K1;
      default: k = ST_NONE;
    endcase
    return k;
  endfunction

  // Write-back that consumes the unit result at each sequence position.
  function automatic step_t wb_of(input pc_t pc);
    step_t w;
    unique case (pc)
      4'd0:    w = W_MEAS;
      4'd2:    w = W_AZ;
      4'd3:    w = W_PAA_ADD;
      4'd4:    w = W_PAA_ADD;
      4'd5:    w = W_PAV_SET;
      4'd7:    w = W_AZ;
      4'd8:    w = W_VEL;
      4'd9:    w = W_PVV_SUB;
      4'd10:   w = W_PVA_SUB;
      4'd11:   w = W_PAV_SUB;
      4'd12:   w = W_PAA_SUB;
      default: w = ST_NONE;
    endcase
    return w;
  endfunction

endpackage

@@ sv/bkt_muldiv.sv @@
// ----------------------------------------------------------------------------
// Bearing tracker multiply-divide unit
// Shift-add multiply of magnitudes, restoring division, rounding half away
// from zero and saturation; can return a wrapped remainder instead.
// ----------------------------------------------------------------------------
module bkt_muldiv import bkt_pkg::*; #(
  parameter int COV_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        mod_mode,
  input  logic signed [COV_WIDTH-1:0] a,
  input  logic signed [COV_WIDTH-1:0] b,
  input  logic        [COV_WIDTH-1:0] c,
  output logic                        done,
  output logic signed [COV_WIDTH-1:0] res
);

  localparam int CW   = COV_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int CNTW = $clog2(PW);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]      phase;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   ua;
  logic [CW-1:0]   cc;
  logic [CW-1:0]   hi;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   rem;
  logic            neg;
  logic            modm;

  logic [CW:0]     mul_sum;
  logic [CW:0]     trial;
  logic            ge;
  logic            up;
  logic [PW:0]     q1;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   mag;
  logic [CW-1:0]   quo;
  logic [CW-1:0]   modr;

  always_comb begin
    mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, ua} : '0);
    trial   = {rem, hi[CW-1]};
    ge      = trial >= {1'b0, cc};
    up      = {rem, 1'b0} >= {1'b0, cc};
    q1      = {1'b0, hi, lo} + {{PW{1'b0}}, up};
    lim     = {neg, {(CW-1){~neg}}};
    mag     = (q1 > {{(PW-CW+1){1'b0}}, lim}) ? lim : q1[CW-1:0];
    quo     = neg ? (~mag + 1'b1) : mag;
    modr    = (neg && (rem != '0)) ? (cc - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          if (cnt == '0) begin
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          if (cnt == '0) begin
            phase <= PH_FIN;
          end
        end
        PH_FIN: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          ua   <= a[CW-1] ? (~a + 1'b1) : a;
          lo   <= b[CW-1] ? (~b + 1'b1) : b;
          hi   <= '0;
          cc   <= c;
          neg  <= a[CW-1] ^ b[CW-1];
          modm <= mod_mode;
          cnt  <= CNTW'(CW - 1);
        end
      end
      PH_MUL: begin
        hi  <= mul_sum[CW:1];
        lo  <= {mul_sum[0], lo[CW-1:1]};
        if (cnt == '0) begin
          cnt <= CNTW'(PW - 1);
          rem <= '0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      PH_DIV: begin
        rem <= ge ? CW'(trial - {1'b0, cc}) : trial[CW-1:0];
        {hi, lo} <= {hi[CW-2:0], lo, ge};
        cnt <= cnt - 1'b1;
      end
      PH_FIN: begin
        res <= modm ? modr : quo;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/bkt_datapath.sv @@
// ----------------------------------------------------------------------------
// Bearing tracker datapath
// Filter state, operand selection for the shared unit, saturating
// write-backs and the output register.
// ----------------------------------------------------------------------------
module bkt_datapath import bkt_pkg::*; #(
  parameter int COV_WIDTH       = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  bkt_cmd_t    cmd,
  output bkt_sts_t    sts,
  input  logic        in_op,
  input  logic [15:0] in_meas,
  input  logic [22:0] in_var,
  input  logic [15:0] in_dt,
  input  logic [15:0] q_az,
  input  logic [15:0] q_vel,
  input  logic [15:0] init_vvar,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [55:0] m_tdata,
  output logic        m_tuser
);

  localparam int CW = COV_WIDTH;
  localparam int FC = 360 << ANGLE_FRAC_BITS;
  localparam int HC = 180 << ANGLE_FRAC_BITS;
  localparam int AW = $clog2(FC);
  localparam int IW = AW + 2;

  localparam logic [AW:0]           FC_A    = (AW+1)'(FC);
  localparam logic [AW:0]           HC_A    = (AW+1)'(HC);
  localparam logic signed [IW-1:0]  FC_S    = IW'(FC);
  localparam logic signed [IW-1:0]  HC_S    = IW'(HC);
  localparam logic signed [CW-1:0]  COV_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]  COV_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0]  ONE     = {{(CW-1){1'b0}}, 1'b1};

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    logic [CW:0] s;
    s = {x[CW-1], x} + {y[CW-1], y};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? COV_MIN : COV_MAX;
    end
    return s[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_sub(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    logic [CW:0] s;
    s = {x[CW-1], x} - {y[CW-1], y};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? COV_MIN : COV_MAX;
    end
    return s[CW-1:0];
  endfunction

  logic                 op_r;
  logic [15:0]          meas_raw;
  logic signed [CW-1:0] r_val;
  logic [9:0]           t_r;
  logic [AW-1:0]        meas_w;
  logic [AW-1:0]        az;
  logic signed [16:0]   vel;
  logic signed [CW-1:0] paa;
  logic signed [CW-1:0] pav;
  logic signed [CW-1:0] pva;
  logic signed [CW-1:0] pvv;
  logic signed [CW-1:0] s_val;
  logic signed [IW-1:0] innov;
  logic                 trk;

  logic                 mdu_start;
  logic                 mdu_mod;
  logic signed [CW-1:0] mdu_a;
  logic signed [CW-1:0] mdu_b;
  logic [CW-1:0]        mdu_c;
  logic                 mdu_done;
  logic signed [CW-1:0] res;

  logic [19:0]          tt;
  logic [22:0]          var_c;
  logic [9:0]           dt_c;
  logic [AW:0]          az_sum;
  logic [AW-1:0]        az_fix;
  logic signed [CW-1:0] dv_clamp;
  logic signed [21:0]   vel_sum;
  logic signed [16:0]   vel_new;
  logic signed [IW-1:0] d_raw;
  logic signed [IW-1:0] d_wrap;
  logic signed [CW-1:0] pav_new;
  logic [AW:0]          back_sum;
  logic [AW-1:0]        back;

  assign tt = {10'd0, t_r} * {10'd0, t_r};

  always_comb begin
    var_c = (in_var < 23'(VAR_MIN)) ? 23'(VAR_MIN) : in_var;
    if (in_dt == 16'd0) begin
      dt_c = 10'd1;
    end else if (in_dt > 16'(DT_MAX)) begin
      dt_c = 10'(DT_MAX);
    end else begin
      dt_c = in_dt[9:0];
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    mdu_start = 1'b1;
    mdu_mod   = 1'b0;
    mdu_a     = paa;
    mdu_b     = ONE;
    mdu_c     = CW'(MS_PER_S);
    unique case (cmd.step)
      K_MEAS_MOD: begin
        mdu_a   = CW'(meas_raw);
        mdu_c   = CW'(FC);
        mdu_mod = 1'b1;
      end
      K_VEL_T: begin
        mdu_a = CW'(vel);
        mdu_b = CW'(t_r);
      end
      K_RES_MOD: begin
        mdu_a   = res;
        mdu_c   = CW'(FC);
        mdu_mod = 1'b1;
      end
      K_PAV_2T: begin
        mdu_a = pav;
        mdu_b = CW'({t_r, 1'b0});
      end
      K_PVV_TT: begin
        mdu_a = pvv;
        mdu_b = CW'(tt);
        mdu_c = CW'(MS2_PER_S2);
      end
      K_PVV_T: begin
        mdu_a = pvv;
        mdu_b = CW'(t_r);
      end
      K_G1: begin
        mdu_a = paa;
        mdu_b = CW'(innov);
        mdu_c = s_val;
      end
      K_G2: begin
        mdu_a = pva;
        mdu_b = CW'(innov);
        mdu_c = s_val;
      end
      K_K4: begin
        mdu_a = pva;
        mdu_b = pav;
        mdu_c = s_val;
      end
      K_K3: begin
        mdu_a = pva;
        mdu_b = paa;
        mdu_c = s_val;
      end
      K_K2: begin
        mdu_a = paa;
        mdu_b = pav;
        mdu_c = s_val;
      end
      K_K1: begin
        mdu_a = paa;
        mdu_b = paa;
        mdu_c = s_val;
      end
      default: mdu_start = 1'b0;
    endcase
  end

  bkt_muldiv #(
    .COV_WIDTH (COV_WIDTH)
  ) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (mdu_start),
    .mod_mode (mdu_mod),
    .a        (mdu_a),
    .b        (mdu_b),
    .c        (mdu_c),
    .done     (mdu_done),
    .res      (res)
  );

  always_comb begin
    // The result is already wrapped, so one subtraction brings the sum back.
    az_sum = {1'b0, az} + {1'b0, res[AW-1:0]};
    az_fix = (az_sum >= FC_A) ? AW'(az_sum - FC_A) : az_sum[AW-1:0];

    if (res > CW'(VEL_STEP)) begin
      dv_clamp = CW'(VEL_STEP);
    end else if (res < -CW'(VEL_STEP)) begin
      dv_clamp = -CW'(VEL_STEP);
    end else begin
      dv_clamp = res;
    end
    vel_sum = 22'(vel) + dv_clamp[21:0];
    if (vel_sum > 22'(VEL_MAX)) begin
      vel_new = 17'(VEL_MAX);
    end else if (vel_sum < 22'(VEL_MIN)) begin
      vel_new = 17'(VEL_MIN);
    end else begin
      vel_new = vel_sum[16:0];
    end

    d_raw = $signed({2'b00, meas_w}) - $signed({2'b00, az});
    priority if (d_raw > HC_S) begin
      d_wrap = d_raw - FC_S;
    end else if (d_raw < -HC_S) begin
      d_wrap = d_raw + FC_S;
    end else begin
      d_wrap = d_raw;
    end

    pav_new  = sat_add(pav, res);
    back_sum = {1'b0, az} + HC_A;
    back     = (back_sum >= FC_A) ? AW'(back_sum - FC_A) : back_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      meas_raw <= in_meas;
      t_r      <= dt_c;
      r_val    <= CW'({var_c, 8'h00});
    end
    unique case (cmd.step)
      W_MEAS:  meas_w <= res[AW-1:0];
      A_INNOV: begin
        innov <= d_wrap;
        s_val <= sat_add(paa, r_val);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      az  <= '0;
      vel <= '0;
      paa <= '0;
      pav <= '0;
      pva <= '0;
      pvv <= '0;
      trk <= 1'b0;
    end else begin
      unique case (cmd.step)
        W_AZ:      az  <= az_fix;
        W_PAA_ADD: paa <= sat_add(paa, res);
        W_PAV_SET: begin
          pav <= pav_new;
          pva <= pav_new;
        end
        W_VEL:     vel <= vel_new;
        W_PVV_SUB: pvv <= sat_sub(pvv, res);
        W_PVA_SUB: pva <= sat_sub(pva, res);
        W_PAV_SUB: pav <= sat_sub(pav, res);
        W_PAA_SUB: paa <= sat_sub(paa, res);
        A_START: begin
          az  <= meas_w;
          vel <= '0;
          paa <= r_val;
          pav <= '0;
          pva <= '0;
          pvv <= CW'({init_vvar, 8'h00});
          trk <= 1'b1;
        end
        A_QNOISE: begin
          paa <= sat_add(paa, CW'({q_az, 8'h00}));
          pvv <= sat_add(pvv, CW'({q_vel, 8'h00}));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'd0, vel, 16'(back), 16'(az)};
      m_tuser <= trk;
    end
  end

  always_comb begin
    sts.mdu_done = mdu_done;
    sts.op       = op_r;
    sts.tracking = trk;
    sts.s_pos    = !s_val[CW-1] && (s_val != '0);
    sts.out_free = !m_tvalid || m_tready;
  end

endmodule

@@ sv/bkt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bearing tracker controller
// Sequences the start, predict and update steps of one item through the
// shared unit and hands the result to the output register.
// ----------------------------------------------------------------------------
module bkt_ctrl import bkt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  bkt_sts_t sts,
  output bkt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_QNOISE = 3'd4;
  localparam logic [2:0] S_INNOV  = 3'd5;
  localparam logic [2:0] S_CHECK  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  pc_t        pc;
  pc_t        pc_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.step   = ST_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          pc_next    = PC_MEAS;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.step   = kick_of(pc);
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mdu_done) begin
          cmd.step = wb_of(pc);
          if (pc == PC_MEAS) begin
            // An idle filter either starts or, for a coast item, holds.
            if (!sts.tracking) begin
              state_next = sts.op ? S_OUT : S_START;
            end else begin
              pc_next    = PC_PREDICT;
              state_next = S_ISSUE;
            end
          end else if (pc == PC_PREDICT_END) begin
            state_next = S_QNOISE;
          end else if (pc == PC_LAST) begin
            state_next = S_OUT;
          end else begin
            pc_next    = pc + pc_t'(1);
            state_next = S_ISSUE;
          end
        end
      end
      S_START: begin
        cmd.step   = A_START;
        state_next = S_OUT;
      end
      S_QNOISE: begin
        cmd.step   = A_QNOISE;
        state_next = sts.op ? S_OUT : S_INNOV;
      end
      S_INNOV: begin
        cmd.step   = A_INNOV;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // A non-positive innovation variance skips the update.
        if (sts.s_pos) begin
          pc_next    = PC_UPDATE;
          state_next = S_ISSUE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= PC_MEAS;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

@@ sv/bearing_kalman_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Bearing Kalman tracker, top level
// Two-state bearing tracker with a stream input, a stream output and an
// APB-style register port.
// ----------------------------------------------------------------------------
// The block tracks one bearing with a two-state (azimuth, angular velocity)
// Kalman filter held in fixed point: angles in 1/2^ANGLE_FRAC_BITS degree and
// covariances in signed COV_WIDTH-bit Q.16. A measurement item starts the
// filter when it is idle, and otherwise runs a predict step and an update step
// with the innovation wrapped into plus or minus 180 degrees; a coast item runs
// the predict step only, and only while tracking. Every item gives exactly one
// result item. Items are handled one at a time. All products and quotients go
// through one shared multiply-divide unit; each operation is a shift-add
// multiply of COV_WIDTH steps and a restoring division of 2*COV_WIDTH steps,
// with an issue step before it and a write-back after it. A measurement item
// while tracking needs 13 such operations; a coast item while tracking needs
// six operations; a starting item needs one and a coast item while idle one
// as well. A result that waits on the output adds its stall to the item after
// it. The input is taken again as soon as an item's result sits in the output
// register, even if that result is still waiting to be taken. Registers may
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module bearing_kalman_tracker_top import bkt_pkg::*; #(
  parameter int COV_WIDTH       = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // measured_azimuth[15:0], meas_variance[38:16],
                                 // dt_ms[54:39], zero fill above
  input  logic        s_tuser,   // op: 0 measurement, 1 coast
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // filtered_azimuth[15:0], reverse_azimuth[31:16],
                                 // angular_velocity[48:32], zero fill above
  output logic        m_tuser,   // tracking
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] q_az;
  logic [15:0] q_vel;
  logic [15:0] init_vvar;
  bkt_cmd_t    cmd;
  bkt_sts_t    sts;

  assign pready = 1'b1;

  // Registers sit at byte addresses 0, 4 and 8 (paddr[1:0] is ignored); address 12 reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_az      <= 16'd128;
      q_vel     <= 16'd26;
      init_vvar <= 16'd2560;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_AZ_NOISE:  q_az      <= pwdata[15:0];
        REG_VEL_NOISE: q_vel     <= pwdata[15:0];
        REG_INIT_VVAR: init_vvar <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_AZ_NOISE:  prdata = {16'd0, q_az};
      REG_VEL_NOISE: prdata = {16'd0, q_vel};
      REG_INIT_VVAR: prdata = {16'd0, init_vvar};
      default:       prdata = 32'd0;
    endcase
  end

  bkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bkt_datapath #(
    .COV_WIDTH       (COV_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_tuser),
    .in_meas   (s_tdata[15:0]),
    .in_var    (s_tdata[38:16]),
    .in_dt     (s_tdata[54:39]),
    .q_az      (q_az),
    .q_vel     (q_vel),
    .init_vvar (init_vvar),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
